FILE: rtl/isometric_tile_pick_and_paint_defines.svh
// Assertion macros used by the back of the isometric tile picker.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ISOMETRIC_TILE_PICK_AND_PAINT_DEFINES_SVH
`define ISOMETRIC_TILE_PICK_AND_PAINT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every rising edge outside reset.
`define ISO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define ISO_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ISO_ASSERT(lbl, clk, rstn, prop, msg)
`define ISO_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

FILE: rtl/isotile_pkg.sv
// Shared types, constants and helper functions for the isometric tile picker.
// No dependencies; every RTL module imports this package.
`default_nettype none

package isotile_pkg;

    // Fixed field widths of the pick request and the result.
    localparam int PICK_W  = 16;
    localparam int ID_W    = 8;
    localparam int FLAG_W  = 8;
    localparam int INDEX_W = 10;

    // Store contents after reset.
    localparam logic [ID_W-1:0]   IMAGE_RESET  = 8'd9;
    localparam logic [FLAG_W-1:0] OPTION_RESET = 8'd0;

    // Default grid geometry.
    localparam int DEF_TILES_ACROSS = 32;
    localparam int DEF_TILES_DOWN   = 32;
    localparam int DEF_TILE_WIDTH   = 128;
    localparam int DEF_TILE_HEIGHT  = 64;

    // One request as it sits in the queue, with its classification.
    typedef struct packed {
        logic signed [PICK_W-1:0] pick_x;
        logic signed [PICK_W-1:0] pick_y;
        logic [ID_W-1:0]          image_id;
        logic [FLAG_W-1:0]        tile_flags;
        logic                     early_miss;
    } pick_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_stat_t;

    // Back status seen by the front.
    typedef struct packed {
        logic clearing;
    } back_stat_t;

    // Signed width that holds any pick point, tile center and their difference.
    function automatic int coord_width(int across, int down, int tw, int th);
        return $clog2(tw * across + th * down + 65536) + 2;
    endfunction

    // Bit width of a counter over n values, at least one bit.
    function automatic int count_width(int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/isometric_tile_pick_and_paint.sv
// Top level of the isometric tile picker: front, request queue and back.
// Depends on isotile_pkg, isotile_front, isotile_queue and isotile_back.
//
//   Channel  Handshake                 Payload
//   pick     pick_valid / pick_stall    pick_x, pick_y, image_id, tile_flags
//   result   result_valid / result_stall  hit, tile_index
//
// After reset the back sweeps the tile stores, one entry per cycle, through every
// entry of the grid; pick_stall stays high during the sweep.
// A pick inside the grid's bounding box waits in the queue; the back then tests the
// tiles in index order and stops at the first hit or after the last tile.
// A pick outside the box is answered as a miss without a scan.
// The queue holds two picks; result_stall holds the finished result and the scan.
`default_nettype none

module isometric_tile_pick_and_paint
    import isotile_pkg::*;
#(
    parameter int TILES_ACROSS = DEF_TILES_ACROSS,
    parameter int TILES_DOWN   = DEF_TILES_DOWN,
    parameter int TILE_WIDTH   = DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT  = DEF_TILE_HEIGHT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     pick_valid,
    output logic                          pick_stall,
    input  wire logic signed [PICK_W-1:0] pick_x,
    input  wire logic signed [PICK_W-1:0] pick_y,
    input  wire logic [ID_W-1:0]          image_id,
    input  wire logic [FLAG_W-1:0]        tile_flags,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic                          hit,
    output logic [INDEX_W-1:0]            tile_index
);

    logic        push;
    pick_t       push_data;
    logic        pop;
    pick_t       head;
    queue_stat_t qstat;
    back_stat_t  bstat;

    // Request intake and classification.
    isotile_front #(
        .TILES_ACROSS (TILES_ACROSS),
        .TILES_DOWN   (TILES_DOWN),
        .TILE_WIDTH   (TILE_WIDTH),
        .TILE_HEIGHT  (TILE_HEIGHT)
    ) u_front (
        .pick_valid (pick_valid),
        .pick_stall (pick_stall),
        .pick_x     (pick_x),
        .pick_y     (pick_y),
        .image_id   (image_id),
        .tile_flags (tile_flags),
        .qstat      (qstat),
        .bstat      (bstat),
        .push       (push),
        .push_data  (push_data)
    );

    // Queue between intake and scan.
    isotile_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Tile scan, store update and result register.
    isotile_back #(
        .TILES_ACROSS (TILES_ACROSS),
        .TILES_DOWN   (TILES_DOWN),
        .TILE_WIDTH   (TILE_WIDTH),
        .TILE_HEIGHT  (TILE_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .bstat        (bstat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hit          (hit),
        .tile_index   (tile_index)
    );

endmodule

`default_nettype wire

FILE: rtl/isotile_front.sv
// Front of the tile picker: accepts pick requests and flags points outside the grid.
// Depends on isotile_pkg.
`default_nettype none

module isotile_front
    import isotile_pkg::*;
#(
    parameter int TILES_ACROSS = DEF_TILES_ACROSS,
    parameter int TILES_DOWN   = DEF_TILES_DOWN,
    parameter int TILE_WIDTH   = DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT  = DEF_TILE_HEIGHT
)
(
    input  wire logic                     pick_valid,
    output logic                          pick_stall,
    input  wire logic signed [PICK_W-1:0] pick_x,
    input  wire logic signed [PICK_W-1:0] pick_y,
    input  wire logic [ID_W-1:0]          image_id,
    input  wire logic [FLAG_W-1:0]        tile_flags,
    input  wire queue_stat_t              qstat,
    input  wire back_stat_t               bstat,
    output logic                          push,
    output pick_t                         push_data
);

    localparam int COORD_W = coord_width(TILES_ACROSS, TILES_DOWN, TILE_WIDTH, TILE_HEIGHT);
    localparam int HALF_W  = TILE_WIDTH / 2;
    localparam int HALF_H  = TILE_HEIGHT / 2;
    localparam int STAGGER = (TILES_DOWN > 1) ? HALF_W : 0;

    // Box that encloses every diamond of the grid.
    localparam logic signed [COORD_W-1:0] X_MIN = COORD_W'(-HALF_W);
    localparam logic signed [COORD_W-1:0] X_MAX =
        COORD_W'(TILE_WIDTH * (TILES_ACROSS - 1) + STAGGER + HALF_W);
    localparam logic signed [COORD_W-1:0] Y_MIN = COORD_W'(-HALF_H);
    localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(HALF_H * TILES_DOWN);

    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;

    // Take a request while the queue has room and the stores are not being cleared.
    assign pick_stall = qstat.full || bstat.clearing;
    assign push       = pick_valid && !pick_stall;

    // A point outside the box cannot hit any tile and skips the scan.
    assign px = COORD_W'(pick_x);
    assign py = COORD_W'(pick_y);

    always_comb
    begin
        push_data.pick_x     = pick_x;
        push_data.pick_y     = pick_y;
        push_data.image_id   = image_id;
        push_data.tile_flags = tile_flags;
        push_data.early_miss = (px < X_MIN) || (px > X_MAX) || (py < Y_MIN) || (py > Y_MAX);
    end

endmodule

`default_nettype wire

FILE: rtl/isotile_queue.sv
// Two-entry request queue between the front and the back of the tile picker.
// Depends on isotile_pkg.
`default_nettype none

module isotile_queue
    import isotile_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire pick_t push_data,
    input  wire logic  pop,
    output pick_t      head,
    output queue_stat_t qstat
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    pick_t      entry_reg [2];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign qstat.full     = (count_reg == 2'd2);
    assign qstat.nonempty = (count_reg != 2'd0);

endmodule

`default_nettype wire

FILE: rtl/isotile_back.sv
// Back of the tile picker: clears the tile stores, scans tiles, paints and reports.
// Depends on isotile_pkg and isometric_tile_pick_and_paint_defines.svh.
`default_nettype none
`include "isometric_tile_pick_and_paint_defines.svh"

module isotile_back
    import isotile_pkg::*;
#(
    parameter int TILES_ACROSS = DEF_TILES_ACROSS,
    parameter int TILES_DOWN   = DEF_TILES_DOWN,
    parameter int TILE_WIDTH   = DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT  = DEF_TILE_HEIGHT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pick_t       head,
    input  wire queue_stat_t qstat,
    output logic             pop,
    output back_stat_t       bstat,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             hit,
    output logic [INDEX_W-1:0] tile_index
);

    localparam int TILE_COUNT = TILES_ACROSS * TILES_DOWN;
    localparam int IDX_W      = count_width(TILE_COUNT);
    localparam int COL_W      = count_width(TILES_ACROSS);
    localparam int COORD_W    = coord_width(TILES_ACROSS, TILES_DOWN, TILE_WIDTH, TILE_HEIGHT);
    localparam int HALF_WI    = TILE_WIDTH / 2;
    localparam int HALF_HI    = TILE_HEIGHT / 2;
    localparam int PROD_W     = COORD_W + $clog2(TILE_WIDTH + 1) + 2;

    localparam logic [IDX_W-1:0]          LAST_IDX = IDX_W'(TILE_COUNT - 1);
    localparam logic [COL_W-1:0]          LAST_COL = COL_W'(TILES_ACROSS - 1);
    localparam logic signed [COORD_W-1:0] STEP_X   = COORD_W'(TILE_WIDTH);
    localparam logic signed [COORD_W-1:0] HALF_WX  = COORD_W'(HALF_WI);
    localparam logic signed [COORD_W-1:0] HALF_HY  = COORD_W'(HALF_HI);
    localparam logic [PROD_W-1:0]         HALF_WP  = PROD_W'(HALF_WI);
    localparam logic [PROD_W-1:0]         HALF_HP  = PROD_W'(HALF_HI);
    localparam logic [PROD_W-1:0]         AREA     = PROD_W'(HALF_WI * HALF_HI);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN
    } back_state_t;

    back_state_t               state_reg;
    logic [IDX_W-1:0]          k_reg;
    logic [COL_W-1:0]          col_reg;
    logic                      odd_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [INDEX_W-1:0]        index_reg;

    logic [ID_W-1:0]   image_mem  [TILE_COUNT];
    logic [FLAG_W-1:0] option_mem [TILE_COUNT];

    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [COORD_W-1:0]        adx;
    logic [COORD_W-1:0]        ady;
    logic [PROD_W-1:0]         diamond_sum;
    logic                      in_diamond;
    logic                      last_tile;
    logic                      out_free;
    logic                      finish_scan;
    logic                      finish_early;
    logic                      start_scan;
    logic                      store_we;
    logic [ID_W-1:0]           image_wr;
    logic [FLAG_W-1:0]         option_wr;

    // Diamond test of the pick point against the tile under the scan counters.
    assign px   = COORD_W'(head.pick_x);
    assign py   = COORD_W'(head.pick_y);
    assign dx   = px - cx_reg;
    assign dy   = py - cy_reg;
    assign adx  = dx[COORD_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    assign ady  = dy[COORD_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    assign diamond_sum = HALF_HP * PROD_W'(adx) + HALF_WP * PROD_W'(ady);
    assign in_diamond  = (diamond_sum <= AREA);
    assign last_tile   = (k_reg == LAST_IDX);

    // Sequencing events; a finished result waits until the output register is free.
    assign out_free     = !out_valid_reg || !result_stall;
    assign finish_scan  = (state_reg == B_SCAN) && (in_diamond || last_tile) && out_free;
    assign finish_early = (state_reg == B_IDLE) && qstat.nonempty && head.early_miss
                          && out_free;
    assign start_scan   = (state_reg == B_IDLE) && qstat.nonempty && !head.early_miss;
    assign pop          = finish_scan || finish_early;

    // Single write port of the stores: clearing sweep or paint on a hit.
    assign store_we  = (state_reg == B_CLEAR) || (finish_scan && in_diamond);
    assign image_wr  = (state_reg == B_CLEAR) ? IMAGE_RESET : head.image_id;
    assign option_wr = (state_reg == B_CLEAR) ? OPTION_RESET : head.tile_flags;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            image_mem[k_reg]  <= image_wr;
            option_mem[k_reg] <= option_wr;
        end
    end

    // Sequencer with its scan counters and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            k_reg         <= '0;
            col_reg       <= '0;
            odd_reg       <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            index_reg     <= '0;
        end
        else
        begin
            // The result register fills on a finished request and empties when taken.
            if (finish_scan || finish_early)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_CLEAR:
                begin
                    if (last_tile)
                    begin
                        state_reg <= B_IDLE;
                        k_reg     <= '0;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                B_IDLE:
                begin
                    if (finish_early)
                    begin
                        hit_reg       <= 1'b0;
                        index_reg     <= '0;
                    end
                    else if (start_scan)
                    begin
                        state_reg <= B_SCAN;
                        k_reg     <= '0;
                        col_reg   <= '0;
                        odd_reg   <= 1'b0;
                        cx_reg    <= '0;
                        cy_reg    <= '0;
                    end
                end
                B_SCAN:
                begin
                    if (in_diamond || last_tile)
                    begin
                        if (out_free)
                        begin
                            hit_reg       <= in_diamond;
                            index_reg     <= in_diamond ? INDEX_W'(k_reg) : '0;
                            state_reg     <= B_IDLE;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (col_reg == LAST_COL)
                        begin
                            col_reg <= '0;
                            odd_reg <= !odd_reg;
                            cx_reg  <= odd_reg ? '0 : HALF_WX;
                            cy_reg  <= cy_reg + HALF_HY;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                            cx_reg  <= cx_reg + STEP_X;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign bstat.clearing = (state_reg == B_CLEAR);
    assign result_valid   = out_valid_reg;
    assign hit            = hit_reg;
    assign tile_index     = index_reg;

    // Checks on the sequencer.
    `ISO_ASSERT(a_pop_has_entry, clk, rst_n, pop |-> qstat.nonempty, "pop from empty queue")
    `ISO_ASSERT(a_no_result_in_clear, clk, rst_n, (state_reg == B_CLEAR) |-> !out_valid_reg,
        "result during store clear")
    `ISO_ASSERT(a_miss_index_zero, clk, rst_n, (out_valid_reg && !hit_reg) |-> (index_reg == '0),
        "miss with nonzero index")
    `ISO_NEVER(a_col_range, clk, rst_n, (state_reg == B_SCAN) && (col_reg > LAST_COL),
        "column counter out of range")

endmodule

`default_nettype wire
